// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CHK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked at the edge after the antecedent holds.
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/tgarle_pkg.sv =====
// Shared constants and types for the run-length TGA truecolor decoder.
`default_nettype none

package tgarle_pkg;

    // Width of the pixel counters of one image.
    localparam int COUNT_WIDTH = 32;

    // Width of the product of two 16-bit size registers.
    localparam int PROD_WIDTH = 32;

    // Largest pixel total that COUNT_WIDTH bits hold, one bit wider than the product.
    localparam logic [PROD_WIDTH:0] COUNT_MAX =
        (PROD_WIDTH + 1)'((34'(1) << COUNT_WIDTH) - 34'(1));

    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 16;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_PIXEL_FORMAT = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2
    } cfg_index_t;

    // The format code is also the position of the last byte of a pixel.
    typedef enum logic [1:0] {
        FMT_GRAY8  = 2'd0,
        FMT_BGR16  = 2'd1,
        FMT_BGR24  = 2'd2,
        FMT_BGRA32 = 2'd3
    } pixel_format_t;

    localparam logic [7:0] RUN_FLAG   = 8'h80;
    localparam logic [7:0] COUNT_MASK = 8'h7F;
    localparam logic [7:0] RGB5_MASK  = 8'hF8;

endpackage

`default_nettype wire

// ===== rtl/core/tga_rle_truecolor_decoder.sv =====
// Top level of the run-length TGA truecolor decoder: byte input, pixel request output.
//
//   Channel | Handshake             | Payload
//   --------+-----------------------+----------------------------------------------
//   config  | cfg_write             | cfg_index, cfg_data (16 bits)
//   input   | in_valid / in_ready   | data_byte, frame_start
//   output  | out_valid / out_ready | red_or_gray, green, blue, alpha, run_length,
//           |                       | image_done
//
// One byte is taken per cycle while in_ready is high. Each accepted byte is decoded in
// the cycle it is accepted, and any pixel request it finishes appears in the output
// register at the next edge. The output register is the only buffer: the input
// stalls only while a request sits there and out_ready is low.
// Reset is asynchronous and active low; it restores bgra32 format and a 1x1 image.
// The pixel total is multiplied out when a size register is written, so the next
// cycle may already carry a byte.
`default_nettype none

module tga_rle_truecolor_decoder
    import tgarle_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,

    input  wire logic                       cfg_write,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data,

    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [7:0]                 data_byte,
    input  wire logic                       frame_start,

    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [7:0]                      red_or_gray,
    output logic [7:0]                      green,
    output logic [7:0]                      blue,
    output logic [7:0]                      alpha,
    output logic [7:0]                      run_length,
    output logic                            image_done
);

    // Configuration registers and the derived pixel total.
    pixel_format_t          fmt_reg;
    logic [15:0]            width_reg;
    logic [15:0]            height_reg;
    logic [COUNT_WIDTH-1:0] total_reg;
    logic [15:0]            width_next;
    logic [15:0]            height_next;
    logic [PROD_WIDTH-1:0]  product;
    logic [COUNT_WIDTH-1:0] total_next;

    // Decoder state.
    logic                   await_reg;
    logic                   run_reg;
    logic [7:0]             left_reg;
    logic [1:0]             pos_reg;
    logic [23:0]            held_reg;
    logic [COUNT_WIDTH-1:0] done_reg;

    logic                   await_next;
    logic                   run_next;
    logic [7:0]             left_next;
    logic [1:0]             pos_next;
    logic [23:0]            held_next;
    logic [COUNT_WIDTH-1:0] done_next;

    // Output register.
    logic                   out_valid_reg;
    logic [7:0]             red_reg;
    logic [7:0]             green_reg;
    logic [7:0]             blue_reg;
    logic [7:0]             alpha_reg;
    logic [7:0]             len_reg;
    logic                   done_flag_reg;

    // Decode signals.
    logic                   in_fire;
    logic                   cur_await;
    logic                   cur_run;
    logic [7:0]             cur_left;
    logic [1:0]             cur_pos;
    logic [23:0]            cur_held;
    logic [COUNT_WIDTH-1:0] cur_done;
    logic [COUNT_WIDTH:0]   remain_diff;
    logic [7:0]             hdr_count;
    logic [7:0]             clamp_count;
    logic [7:0]             c0;
    logic [7:0]             c1;
    logic [7:0]             c2;
    logic [7:0]             c3;
    logic [7:0]             pix_r;
    logic [7:0]             pix_g;
    logic [7:0]             pix_b;
    logic [7:0]             pix_a;
    logic [7:0]             pix_len;
    logic                   produce;
    logic [COUNT_WIDTH-1:0] done_sum;

    // ------------------------------------------------------------------
    // Configuration. The pixel total is computed from the value being
    // written, so it is ready together with the register it depends on.
    // The total saturates when it does not fit in the pixel counters.
    // ------------------------------------------------------------------
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_write && cfg_index == CFG_IMAGE_WIDTH)
        begin
            width_next = cfg_data;
        end
        if (cfg_write && cfg_index == CFG_IMAGE_HEIGHT)
        begin
            height_next = cfg_data;
        end
        product = PROD_WIDTH'(width_next) * PROD_WIDTH'(height_next);
        if ({1'b0, product} > COUNT_MAX)
        begin
            total_next = COUNT_WIDTH'(COUNT_MAX);
        end
        else
        begin
            total_next = COUNT_WIDTH'(product);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg    <= FMT_BGRA32;
            width_reg  <= 16'd1;
            height_reg <= 16'd1;
            total_reg  <= COUNT_WIDTH'(1);
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_PIXEL_FORMAT)
            begin
                fmt_reg <= pixel_format_t'(cfg_data[1:0]);
            end
            width_reg  <= width_next;
            height_reg <= height_next;
            total_reg  <= total_next;
        end
    end

    // ------------------------------------------------------------------
    // Handshake. A new byte is taken whenever the output register is
    // empty or is being emptied in the same cycle.
    // ------------------------------------------------------------------
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // ------------------------------------------------------------------
    // Byte decode. A frame start byte first clears the decoder state and
    // is then decoded as the first packet header of the image.
    // ------------------------------------------------------------------
    always_comb
    begin
        if (frame_start)
        begin
            cur_await = 1'b1;
            cur_run   = 1'b0;
            cur_left  = 8'd0;
            cur_pos   = 2'd0;
            cur_held  = 24'd0;
            cur_done  = '0;
        end
        else
        begin
            cur_await = await_reg;
            cur_run   = run_reg;
            cur_left  = left_reg;
            cur_pos   = pos_reg;
            cur_held  = held_reg;
            cur_done  = done_reg;
        end

        // Pixels left in the image; the borrow bit means none are left.
        remain_diff = {1'b0, total_reg} - {1'b0, cur_done};
        hdr_count   = (data_byte & COUNT_MASK) + 8'd1;
        if (remain_diff[COUNT_WIDTH])
        begin
            clamp_count = 8'd0;
        end
        else if (remain_diff[COUNT_WIDTH-1:8] != '0)
        begin
            clamp_count = hdr_count;
        end
        else if (remain_diff[7:0] < hdr_count)
        begin
            clamp_count = remain_diff[7:0];
        end
        else
        begin
            clamp_count = hdr_count;
        end

        // Pixel channels: the held bytes with the current byte in the
        // last position of the format.
        c0 = cur_held[7:0];
        c1 = cur_held[15:8];
        c2 = cur_held[23:16];
        c3 = 8'd0;
        case (fmt_reg)
            FMT_GRAY8:  c0 = data_byte;
            FMT_BGR16:  c1 = data_byte;
            FMT_BGR24:  c2 = data_byte;
            default:    c3 = data_byte;
        endcase

        case (fmt_reg)
            FMT_GRAY8:
            begin
                pix_r = c0;
                pix_g = 8'd0;
                pix_b = 8'd0;
                pix_a = 8'd0;
            end
            FMT_BGR16:
            begin
                // Five bits per channel, placed at the top of each byte.
                pix_r = {c1[6:2], 3'b000} & RGB5_MASK;
                pix_g = {c1[1:0], c0[7:5], 3'b000} & RGB5_MASK;
                pix_b = {c0[4:0], 3'b000} & RGB5_MASK;
                pix_a = 8'd0;
            end
            FMT_BGR24:
            begin
                pix_r = c2;
                pix_g = c1;
                pix_b = c0;
                pix_a = 8'd0;
            end
            default:
            begin
                pix_r = c2;
                pix_g = c1;
                pix_b = c0;
                pix_a = c3;
            end
        endcase

        await_next = cur_await;
        run_next   = cur_run;
        left_next  = cur_left;
        pos_next   = cur_pos;
        held_next  = cur_held;
        pix_len    = 8'd0;

        if (cur_await)
        begin
            // Packet header. A raw packet with nothing left to emit is
            // followed directly by another header; a run always takes
            // its pixel bytes.
            run_next   = (data_byte & RUN_FLAG) != 8'd0;
            left_next  = clamp_count;
            pos_next   = 2'd0;
            held_next  = 24'd0;
            await_next = !run_next && clamp_count == 8'd0;
        end
        else if (cur_pos < fmt_reg)
        begin
            // Early byte of a pixel: hold it at its byte lane.
            case (cur_pos)
                2'd0:    held_next = cur_held | {16'd0, data_byte};
                2'd1:    held_next = cur_held | {8'd0, data_byte, 8'd0};
                default: held_next = cur_held | {data_byte, 16'd0};
            endcase
            pos_next = cur_pos + 2'd1;
        end
        else
        begin
            // Last byte of a pixel. A run reports its whole length once.
            pos_next  = 2'd0;
            held_next = 24'd0;
            if (cur_run)
            begin
                pix_len    = cur_left;
                left_next  = 8'd0;
                await_next = 1'b1;
            end
            else
            begin
                if (cur_left != 8'd0)
                begin
                    pix_len   = 8'd1;
                    left_next = cur_left - 8'd1;
                end
                if (left_next == 8'd0)
                begin
                    await_next = 1'b1;
                end
            end
        end

        produce  = pix_len != 8'd0;
        done_sum = cur_done + COUNT_WIDTH'(pix_len);
        done_next = produce ? done_sum : cur_done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            await_reg <= 1'b1;
            run_reg   <= 1'b0;
            left_reg  <= 8'd0;
            pos_reg   <= 2'd0;
            held_reg  <= 24'd0;
            done_reg  <= '0;
        end
        else if (in_fire)
        begin
            await_reg <= await_next;
            run_reg   <= run_next;
            left_reg  <= left_next;
            pos_reg   <= pos_next;
            held_reg  <= held_next;
            done_reg  <= done_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register. Valid is set by a byte that completes a request and
    // cleared when the request is taken without a replacement.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= produce;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && produce)
        begin
            red_reg       <= pix_r;
            green_reg     <= pix_g;
            blue_reg      <= pix_b;
            alpha_reg     <= pix_a;
            len_reg       <= pix_len;
            done_flag_reg <= done_sum == total_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign red_or_gray = red_reg;
    assign green       = green_reg;
    assign blue        = blue_reg;
    assign alpha       = alpha_reg;
    assign run_length  = len_reg;
    assign image_done  = done_flag_reg;

endmodule

`default_nettype wire

// ===== rtl/core/tgarle_checker.sv =====
// Port-level checker for the run-length TGA truecolor decoder, with its bind.
`default_nettype none

`include "assert_macros.svh"

module tgarle_checker
    import tgarle_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       frame_start,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] red_or_gray,
    input wire logic [7:0] green,
    input wire logic [7:0] blue,
    input wire logic [7:0] alpha,
    input wire logic [7:0] run_length,
    input wire logic       image_done
);

    // A request waiting in the output register holds its payload.
    `CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(red_or_gray) && $stable(green) && $stable(blue) && $stable(alpha) && $stable(run_length) && $stable(image_done), "output request changed while stalled")

    // Every request covers between one and one hundred twenty-eight pixels.
    `CHK_ALWAYS(a_len_range, !out_valid || (run_length != 8'd0 && run_length <= 8'd128), "run length out of range")

    // The input is blocked exactly while a request is stalled at the output.
    `CHK_ALWAYS(a_ready_map, in_ready == (!out_valid || out_ready), "input ready does not follow the output stall")

    // A frame start byte is always a packet header and makes no request.
    `CHK_NEXT(a_hdr_quiet, in_valid && in_ready && frame_start, !out_valid, "frame start byte produced a request")

endmodule

bind tga_rle_truecolor_decoder tgarle_checker u_tgarle_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .frame_start (frame_start),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .red_or_gray (red_or_gray),
    .green       (green),
    .blue        (blue),
    .alpha       (alpha),
    .run_length  (run_length),
    .image_done  (image_done)
);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the run-length TGA truecolor decoder.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tgarle_pkg::*;

    // Cycles in a row with no request moving on either channel before the run
    // is declared hung. The longest legitimate quiet stretch is the long
    // receiver hold, so this leaves a wide margin.
    localparam int STALL_LIMIT = 2000;

    // One byte of the encoded stream as the sender offers it.
    typedef struct packed {
        logic [7:0] value;
        logic       sof;
    } stream_byte_t;

    // One pixel request as the decoder emits it.
    typedef struct packed {
        logic [7:0] red_or_gray;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] run_length;
        logic       image_done;
    } pixel_req_t;

    // ------------------------------------------------------------------
    // Clock, reset and the signals around the block. Every input starts
    // from a known value at time zero.
    // ------------------------------------------------------------------
    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       cfg_write   = 1'b0;
    cfg_index_t cfg_index   = CFG_PIXEL_FORMAT;
    logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;
    logic       in_valid    = 1'b0;
    logic       in_ready;
    logic [7:0] data_byte   = 8'h00;
    logic       frame_start = 1'b0;
    logic       out_valid;
    logic       out_ready   = 1'b0;
    logic [7:0] red_or_gray;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] run_length;
    logic       image_done;

    always #10 clk = ~clk;

    tga_rle_truecolor_decoder u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .red_or_gray (red_or_gray),
        .green       (green),
        .blue        (blue),
        .alpha       (alpha),
        .run_length  (run_length),
        .image_done  (image_done)
    );

    // ------------------------------------------------------------------
    // Bookkeeping shared by the processes below.
    // ------------------------------------------------------------------
    stream_byte_t encoded_bytes[$];    // bytes waiting for the sender
    pixel_req_t   pending_pixels[$];   // predicted requests, oldest first
    int           errors       = 0;
    int           bytes_taken  = 0;    // bytes accepted by the block
    int           send_gap     = 0;
    int           stall_left   = 0;
    int           quiet_cycles = 0;
    logic         long_hold_done = 1'b0;
    logic         calm = 1'b0;         // set for the last phase: no idling at all

    // ------------------------------------------------------------------
    // Decoder prediction. These variables mirror the configuration
    // registers and the decoder state; after their start values they
    // change only through write_reg() and decode_byte().
    // ------------------------------------------------------------------
    pixel_format_t          m_fmt;
    logic [15:0]            m_width;
    logic [15:0]            m_rows;
    logic                   m_await;
    logic                   m_run;
    logic [7:0]             m_left;
    logic [1:0]             m_pos;
    logic [23:0]            m_held;
    logic [COUNT_WIDTH-1:0] m_done;

    task automatic clear_decoder();
        m_await = 1'b1;
        m_run   = 1'b0;
        m_left  = 8'd0;
        m_pos   = 2'd0;
        m_held  = 24'd0;
        m_done  = '0;
    endtask

    // Decodes one accepted byte and queues the pixel request it causes, if any.
    task automatic decode_byte(input logic [7:0] b, input logic sof);
        logic [PROD_WIDTH-1:0]  area;
        logic [COUNT_WIDTH-1:0] total;
        logic [COUNT_WIDTH-1:0] remaining;
        logic [7:0]             count;
        logic [7:0]             run_len;
        logic [7:0]             c0, c1, c2, c3;
        logic [7:0]             red, grn, blu, alf;
        pixel_req_t             px;

        if (sof)
            clear_decoder();

        // The pixel total saturates at the counter width.
        area  = PROD_WIDTH'(m_width) * PROD_WIDTH'(m_rows);
        total = ({1'b0, area} > COUNT_MAX) ? COUNT_MAX[COUNT_WIDTH-1:0]
                                           : area[COUNT_WIDTH-1:0];

        // Packet header: the count is clamped to the pixels still missing.
        // A raw header clamped to zero is followed by another header.
        if (m_await)
        begin
            count     = (b & COUNT_MASK) + 8'd1;
            remaining = (m_done < total) ? total - m_done : '0;
            if (COUNT_WIDTH'(count) > remaining)
                count = remaining[7:0];
            m_run   = (b & RUN_FLAG) != 8'd0;
            m_left  = count;
            m_pos   = 2'd0;
            m_held  = 24'd0;
            m_await = !m_run && (count == 8'd0);
            return;
        end

        // The format code is also the index of the last byte of a pixel.
        // Earlier bytes are only collected.
        if (m_pos < m_fmt)
        begin
            m_held = m_held | (24'(b) << (8 * m_pos));
            m_pos  = m_pos + 2'd1;
            return;
        end

        // Last byte of the pixel. After a format change in mid-pixel the
        // byte lands in the slot of the new format's last byte.
        c0 = m_held[7:0];
        c1 = m_held[15:8];
        c2 = m_held[23:16];
        c3 = 8'd0;
        case (m_fmt)
            FMT_GRAY8: c0 = b;
            FMT_BGR16: c1 = b;
            FMT_BGR24: c2 = b;
            default:   c3 = b;
        endcase

        case (m_fmt)
            FMT_GRAY8:
            begin
                red = c0;
                grn = 8'd0;
                blu = 8'd0;
                alf = 8'd0;
            end
            FMT_BGR16:
            begin
                // Little-endian 16-bit word: x RRRRR GGGGG BBBBB.
                red = {c1[6:0], 1'b0} & RGB5_MASK;
                grn = ({c1[1:0], 6'd0} | (c0 >> 2)) & RGB5_MASK;
                blu = {c0[4:0], 3'd0} & RGB5_MASK;
                alf = 8'd0;
            end
            FMT_BGR24:
            begin
                red = c2;
                grn = c1;
                blu = c0;
                alf = 8'd0;
            end
            default:
            begin
                red = c2;
                grn = c1;
                blu = c0;
                alf = c3;
            end
        endcase

        m_pos  = 2'd0;
        m_held = 24'd0;

        // A run ends its packet with one request for the whole run; a raw
        // packet counts down one pixel at a time.
        if (m_run)
        begin
            run_len = m_left;
            m_left  = 8'd0;
            m_await = 1'b1;
        end
        else
        begin
            run_len = (m_left != 8'd0) ? 8'd1 : 8'd0;
            if (m_left != 8'd0)
                m_left = m_left - 8'd1;
            if (m_left == 8'd0)
                m_await = 1'b1;
        end

        // A run clamped to zero swallows its pixel without a request.
        if (run_len == 8'd0)
            return;

        m_done = m_done + COUNT_WIDTH'(run_len);
        px = '{red_or_gray: red, green: grn, blue: blu, alpha: alf,
               run_length: run_len, image_done: (m_done == total)};
        pending_pixels.push_back(px);
    endtask

    // ------------------------------------------------------------------
    // Sender. Bytes come from encoded_bytes; valid stays up with a steady
    // payload until the block takes the byte. Prediction happens at the
    // edge where the byte is accepted.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        stream_byte_t next_item;
        logic         offer;

        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            data_byte   <= 8'h00;
            frame_start <= 1'b0;
            send_gap    <= 0;
            bytes_taken <= 0;
        end
        else
        begin
            offer = 1'b0;
            if (in_valid && in_ready)
            begin
                decode_byte(data_byte, frame_start);
                bytes_taken <= bytes_taken + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                    send_gap <= send_gap - 1;
                else if (encoded_bytes.size() != 0)
                begin
                    // Now and then the sender goes quiet.
                    if (!calm && $urandom_range(0, 15) == 0)
                        send_gap <= $urandom_range(0, 9);
                    else
                    begin
                        next_item   = encoded_bytes.pop_front();
                        data_byte   <= next_item.value;
                        frame_start <= next_item.sof;
                        offer       = 1'b1;
                    end
                end
                in_valid <= offer;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver. Ready drops in random bursts. Once, after 150 bytes have
    // gone in, it holds off while the sender keeps offering, so the
    // output register fills and the input side has to stall.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready      <= 1'b0;
            stall_left     <= 0;
            long_hold_done <= 1'b0;
        end
        else if (!long_hold_done && bytes_taken >= 150)
        begin
            long_hold_done <= 1'b1;
            stall_left     <= 119;
            out_ready      <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 11) == 0)
        begin
            stall_left <= $urandom_range(0, 9);
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Checker. Every accepted request is compared field by field with the
    // oldest prediction.
    // ------------------------------------------------------------------
    task automatic check_field(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        pixel_req_t want;

        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: unexpected pixel request r=%h g=%h b=%h a=%h run=%0d done=%b",
                         $time, red_or_gray, green, blue, alpha, run_length, image_done);
                errors++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                check_field("red_or_gray", want.red_or_gray, red_or_gray);
                check_field("green", want.green, green);
                check_field("blue", want.blue, blue);
                check_field("alpha", want.alpha, alpha);
                check_field("run_length", want.run_length, run_length);
                check_field("image_done", 8'(want.image_done), 8'(image_done));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any request moving ends the run.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == STALL_LIMIT)
        begin
            $display("%0t: timeout, no request moved for %0d cycles", $time, STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    task automatic push_byte(logic [7:0] value, logic sof);
        encoded_bytes.push_back('{value: value, sof: sof});
    endtask

    // Register writes happen only while the block is idle, so the
    // predicted copy can follow right away.
    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_WIDTH-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_PIXEL_FORMAT: m_fmt   = pixel_format_t'(value[1:0]);
            CFG_IMAGE_WIDTH:  m_width = value;
            CFG_IMAGE_HEIGHT: m_rows  = value;
            default: ;
        endcase
    endtask

    task automatic set_image(pixel_format_t fmt, logic [15:0] w, logic [15:0] h);
        write_reg(CFG_PIXEL_FORMAT, CFG_DATA_WIDTH'(fmt));
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
    endtask

    // Sender pause: hold back until every byte is in and every predicted
    // request has come out, then let the block settle, since the last
    // bytes may have caused no request at all.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (encoded_bytes.size() != 0 || in_valid || pending_pixels.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // One well-formed image: a header flagged as frame start, then packets
    // whose pixel bytes match the clamped counts. Large images stop after a
    // dozen packets. Sometimes packets follow after the image is full.
    task automatic send_frame();
        int unsigned left;
        int unsigned count;
        int unsigned clamped;
        int unsigned pixels;
        int          pkt;
        int          extra;
        logic        is_run;
        logic        busy;

        left  = 32'(m_width) * 32'(m_rows);
        extra = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
        pkt   = 0;
        busy  = 1'b1;
        while (busy)
        begin
            is_run = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 7) == 0 && (is_run || left < 16))
                count = 128;
            else
                count = $urandom_range(1, 8);
            clamped = (count > left) ? left : count;
            push_byte({is_run, 7'(count - 1)}, pkt == 0);
            // A run always carries its pixel; a raw packet carries as many
            // pixels as survive the clamp.
            pixels = is_run ? 1 : clamped;
            repeat (pixels * (int'(m_fmt) + 1))
                push_byte(8'($urandom_range(0, 255)), 1'b0);
            left = left - clamped;
            pkt++;
            if (left == 0 || pkt >= 12)
            begin
                if (extra == 0)
                    busy = 1'b0;
                else
                    extra--;
            end
        end
    endtask

    // Random bytes with an occasional frame start: broken packets.
    task automatic send_noise();
        repeat ($urandom_range(1, 6))
            push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    endtask

    // Fills the queue with a mix of images and noise, then waits it out.
    task automatic run_phase(int unsigned items);
        int unsigned goal;

        goal = encoded_bytes.size() + items;
        while (encoded_bytes.size() < goal)
        begin
            if ($urandom_range(0, 6) == 0)
                send_noise();
            else
                send_frame();
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial
    begin
        // Register values after reset: bgra32, 1x1 image.
        m_fmt    = FMT_BGRA32;
        m_width  = 16'd1;
        m_rows   = 16'd1;
        clear_decoder();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // bgra32 on a 1x1 image. A one-pixel run fills the image. After that
        // a raw header clamps to zero, so the next byte is a header again,
        // and a run clamped to zero eats its four bytes without a request.
        // The last frame stops two bytes into a pixel.
        push_byte(8'h80, 1'b1);
        push_byte(8'h01, 1'b0);
        push_byte(8'h02, 1'b0);
        push_byte(8'h03, 1'b0);
        push_byte(8'h04, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h11, 1'b0);
        push_byte(8'h22, 1'b0);
        push_byte(8'h33, 1'b0);
        push_byte(8'h44, 1'b0);
        push_byte(8'h00, 1'b1);
        push_byte(8'hA5, 1'b0);
        push_byte(8'h5A, 1'b0);
        wait_drained();

        // Switch to bgr16 with that pixel half done: the next byte completes
        // it. Then a two-pixel run of all ones and a raw packet of 128 that
        // clamps to the one pixel left.
        set_image(FMT_BGR16, 16'd3, 16'd1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h81, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h7F, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h80, 1'b0);
        wait_drained();

        // gray8 on the largest image: a full 128-pixel run, then raw black.
        set_image(FMT_GRAY8, 16'hFFFF, 16'hFFFF);
        push_byte(8'hFF, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        wait_drained();

        // bgr24 byte order.
        set_image(FMT_BGR24, 16'd1, 16'd2);
        push_byte(8'h00, 1'b1);
        push_byte(8'h10, 1'b0);
        push_byte(8'h20, 1'b0);
        push_byte(8'h30, 1'b0);
        wait_drained();

        // Random phases over all formats and both ends of the size range.
        set_image(FMT_GRAY8, 16'd4, 16'd3);
        run_phase(75);
        set_image(FMT_BGR16, 16'hFFFF, 16'd1);
        run_phase(75);
        set_image(FMT_BGR24, 16'd5, 16'd2);
        run_phase(75);
        // A zero height gives an empty image: every count clamps to zero.
        set_image(FMT_BGRA32, 16'd1, 16'd0);
        run_phase(40);
        set_image(FMT_BGR16, 16'd3, 16'd4);
        run_phase(75);
        set_image(pixel_format_t'($urandom_range(0, 3)), 16'($urandom_range(1, 6)),
                  16'($urandom_range(1, 4)));
        run_phase(75);
        set_image(FMT_BGRA32, 16'd2, 16'hFFFF);
        run_phase(75);

        // Last phase runs back to back on both sides.
        calm = 1'b1;
        set_image(pixel_format_t'($urandom_range(0, 3)), 16'($urandom_range(1, 6)),
                  16'($urandom_range(1, 4)));
        run_phase(75);

        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
